// File: rtl/awsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awsm_pkg
// Shared widths, register codes and types for the angle smoothing block.
// ----------------------------------------------------------------------------
package awsm_pkg;

	localparam int ANGLE_BITS_DEF       = 16;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;

	localparam int DIST_BITS = 16;  // max_distance register
	localparam int WREG_BITS = 19;  // signed weight registers
	localparam int DIV_STEP  = 4;   // quotient bits per divider stage

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [DIST_BITS-1:0] MAX_DIST_RST = '0;
	localparam logic [WREG_BITS-1:0] MIN_W_RST    = 19'd32768;
	localparam logic [WREG_BITS-1:0] MAX_W_RST    = 19'd65536;

	typedef enum logic [1:0] {
		REG_MAX_DIST = 2'd0,
		REG_MIN_W    = 2'd1,
		REG_MAX_W    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [DIST_BITS-1:0]        max_distance;
		logic signed [WREG_BITS-1:0] min_weight;
		logic signed [WREG_BITS-1:0] max_weight;
	} cfg_t;

endpackage
`default_nettype wire

// File: rtl/awsm_sample_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awsm_sample_if
// Input channel: current and previous angles of three axes.
// ----------------------------------------------------------------------------
interface awsm_sample_if
	import awsm_pkg::*;
	#(parameter int ANGLE_BITS = ANGLE_BITS_DEF) ();

	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] current_yaw;
	logic signed [ANGLE_BITS-1:0] current_pitch;
	logic signed [ANGLE_BITS-1:0] current_roll;
	logic signed [ANGLE_BITS-1:0] previous_yaw;
	logic signed [ANGLE_BITS-1:0] previous_pitch;
	logic signed [ANGLE_BITS-1:0] previous_roll;

	modport source (
		output valid, current_yaw, current_pitch, current_roll,
		       previous_yaw, previous_pitch, previous_roll,
		input  ready
	);

	modport sink (
		input  valid, current_yaw, current_pitch, current_roll,
		       previous_yaw, previous_pitch, previous_roll,
		output ready
	);

endinterface
`default_nettype wire

// File: rtl/awsm_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awsm_result_if
// Output channel: smoothed angles of three axes.
// ----------------------------------------------------------------------------
interface awsm_result_if
	import awsm_pkg::*;
	#(parameter int ANGLE_BITS = ANGLE_BITS_DEF) ();

	logic                         valid;
	logic                         ready;
	logic signed [ANGLE_BITS-1:0] smoothed_yaw;
	logic signed [ANGLE_BITS-1:0] smoothed_pitch;
	logic signed [ANGLE_BITS-1:0] smoothed_roll;

	modport source (
		output valid, smoothed_yaw, smoothed_pitch, smoothed_roll,
		input  ready
	);

	modport sink (
		input  valid, smoothed_yaw, smoothed_pitch, smoothed_roll,
		output ready
	);

endinterface
`default_nettype wire

// File: rtl/angle_weighted_smoothing.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// angle_weighted_smoothing
// Adaptive exponential smoothing of yaw, pitch and roll binary angles.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            word
//  -------   ---   ------------------   ----------------------------------
//  sample    in    valid/ready          current_* and previous_* angles
//  result    out   valid/ready          smoothed_* angles
//  apb       in    psel/penable/pready  max_distance, min_weight, max_weight
//
//  One word per cycle sustained while the output is not stalled. The
//  pipeline holds one difference stage, NDIV divider slices of DIV_STEP
//  quotient bits each, weight multiply, weight clamp, blend multiply and
//  the output register. The divider slices set the depth.
//  Reset clears the stage valid bits and loads the register defaults;
//  payload registers are not reset. A stall at the output backs up stage
//  by stage; empty stages keep filling, so bubbles close up. sample.ready
//  is high whenever the output register is empty.
//
module angle_weighted_smoothing
	import awsm_pkg::*;
#(
	parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	awsm_sample_if.sink             sample,
	awsm_result_if.source           result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	localparam int NDIV = (WEIGHT_FRAC_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int NST  = NDIV + 5;

	cfg_t           cfg;
	logic [NST-1:0] vld_s;   // one valid bit per pipeline stage
	logic [NST-1:0] en;      // stage load enables

	awsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// A stage loads when it is empty or its word moves on this cycle.
	always_comb begin
		en[NST-1] = !vld_s[NST-1] || result.ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= sample.valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign sample.ready = en[0];
	assign result.valid = vld_s[NST-1];

	awsm_axis #(
		.ANGLE_BITS       (ANGLE_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
		.NDIV             (NDIV),
		.NST              (NST)
	) u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (vld_s),
		.cfg      (cfg),
		.cur      (sample.current_yaw),
		.prev     (sample.previous_yaw),
		.smoothed (result.smoothed_yaw)
	);

	awsm_axis #(
		.ANGLE_BITS       (ANGLE_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
		.NDIV             (NDIV),
		.NST              (NST)
	) u_pitch (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (vld_s),
		.cfg      (cfg),
		.cur      (sample.current_pitch),
		.prev     (sample.previous_pitch),
		.smoothed (result.smoothed_pitch)
	);

	awsm_axis #(
		.ANGLE_BITS       (ANGLE_BITS),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS),
		.NDIV             (NDIV),
		.NST              (NST)
	) u_roll (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld      (vld_s),
		.cfg      (cfg),
		.cur      (sample.current_roll),
		.prev     (sample.previous_roll),
		.smoothed (result.smoothed_roll)
	);

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[NST-1] |-> sample.ready)
		else $error("input blocked while output register empty");

	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		sample.valid && sample.ready |=> vld_s[0])
		else $error("accepted word missing from first stage");

	a_hold_first: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] && !en[1] |=> vld_s[0])
		else $error("first stage word lost under stall");

endmodule
`default_nettype wire

// File: rtl/awsm_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awsm_cfg
// APB register file: max distance and the two interpolation weights.
// ----------------------------------------------------------------------------
module awsm_cfg
	import awsm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic [DIST_BITS-1:0] max_distance_q;
	logic [WREG_BITS-1:0] min_weight_q;
	logic [WREG_BITS-1:0] max_weight_q;
	logic                 wr_en;
	reg_idx_t             idx;

	// word-aligned; low address bits ignored
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q <= MAX_DIST_RST;
			min_weight_q   <= MIN_W_RST;
			max_weight_q   <= MAX_W_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_MAX_DIST: max_distance_q <= pwdata[DIST_BITS-1:0];
				REG_MIN_W:    min_weight_q   <= pwdata[WREG_BITS-1:0];
				REG_MAX_W:    max_weight_q   <= pwdata[WREG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAX_DIST: prdata = PDATA_W'(max_distance_q);
			REG_MIN_W:    prdata = PDATA_W'(min_weight_q);
			REG_MAX_W:    prdata = PDATA_W'(max_weight_q);
			default:      prdata = '0;
		endcase
	end

	assign cfg.max_distance = max_distance_q;
	assign cfg.min_weight   = signed'(min_weight_q);
	assign cfg.max_weight   = signed'(max_weight_q);

endmodule
`default_nettype wire

// File: rtl/awsm_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awsm_div_stage
// One registered slice of the restoring divider, DIV_STEP quotient bits.
// ----------------------------------------------------------------------------
module awsm_div_stage
	import awsm_pkg::*;
#(
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
	parameter int FIRST_BIT        = 0
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [DIST_BITS-1:0]        divisor,
	input  wire logic [DIST_BITS-1:0]        rem_i,
	input  wire logic [WEIGHT_FRAC_BITS-1:0] quot_i,
	output logic      [DIST_BITS-1:0]        rem_s2,
	output logic      [WEIGHT_FRAC_BITS-1:0] quot_s2
);

	localparam int F = WEIGHT_FRAC_BITS;

	logic [DIST_BITS-1:0] rem_c;
	logic [F-1:0]         quot_c;

	// remainder stays below the divisor, so the doubled value needs one bit more
	always_comb begin
		logic [DIST_BITS:0] dbl;
		rem_c  = rem_i;
		quot_c = quot_i;
		for (int j = 0; j < DIV_STEP; j++) begin
			if (FIRST_BIT + j < F) begin
				dbl = {rem_c, 1'b0};
				if (dbl >= {1'b0, divisor}) begin
					rem_c  = DIST_BITS'(dbl - {1'b0, divisor});
					quot_c = {quot_c[F-2:0], 1'b1};
				end else begin
					rem_c  = dbl[DIST_BITS-1:0];
					quot_c = {quot_c[F-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2  <= rem_c;
			quot_s2 <= quot_c;
		end
	end

endmodule
`default_nettype wire

// File: rtl/awsm_axis.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// awsm_axis
// Datapath of one axis: wrap difference, alpha divide, weight, blend.
// ----------------------------------------------------------------------------
module awsm_axis
	import awsm_pkg::*;
#(
	parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
	parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF,
	parameter int NDIV             = (WEIGHT_FRAC_BITS + DIV_STEP - 1) / DIV_STEP,
	parameter int NST              = NDIV + 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [NST-1:0]               en,
	input  wire logic [NST-1:0]               vld,
	input  wire cfg_t                         cfg,
	input  wire logic signed [ANGLE_BITS-1:0] cur,
	input  wire logic signed [ANGLE_BITS-1:0] prev,
	output logic signed [ANGLE_BITS-1:0]      smoothed
);

	localparam int A  = ANGLE_BITS;
	localparam int F  = WEIGHT_FRAC_BITS;
	localparam int MW = A + DIST_BITS;
	localparam int WD = WREG_BITS + 1;
	localparam int PW = WD + F + 2;
	localparam int DW = A + F + 2;
	localparam int S3 = NDIV + 1;
	localparam int S4 = NDIV + 2;
	localparam int S5 = NDIV + 3;
	localparam int S6 = NDIV + 4;

	localparam logic [F:0]              W_ONE  = {1'b1, {F{1'b0}}};
	localparam logic signed [PW-1:0]    ONE_PW = {{(PW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

	// stage 1: wrapped difference, magnitude, saturation test
	logic signed [A-1:0]   d_c;
	logic [A-1:0]          mag_c;
	logic [MW-1:0]         mag_ext;
	logic                  sat_c;

	logic signed [A-1:0]   d_s1;
	logic signed [A-1:0]   prev_s1;
	logic                  sat_s1;
	logic [DIST_BITS-1:0]  rem_s1;

	assign d_c     = cur - prev;
	assign mag_c   = d_c[A-1] ? A'(-d_c) : A'(d_c);
	assign mag_ext = MW'(mag_c);
	assign sat_c   = mag_ext >= MW'(cfg.max_distance);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d_s1    <= d_c;
			prev_s1 <= prev;
			sat_s1  <= sat_c;
			rem_s1  <= mag_ext[DIST_BITS-1:0];
		end
	end

	// stage 2: divider slices; when not saturated mag < max_distance, so
	// the quotient fits in F bits
	logic signed [A-1:0]  d_s2    [NDIV];
	logic signed [A-1:0]  prev_s2 [NDIV];
	logic                 sat_s2  [NDIV];
	logic [DIST_BITS-1:0] rem_s2  [NDIV];
	logic [F-1:0]         quot_s2 [NDIV];

	for (genvar s = 0; s < NDIV; s++) begin : g_div
		logic signed [A-1:0]  d_in;
		logic signed [A-1:0]  prev_in;
		logic                 sat_in;
		logic [DIST_BITS-1:0] rem_in;
		logic [F-1:0]         quot_in;

		if (s == 0) begin : g_first
			assign d_in    = d_s1;
			assign prev_in = prev_s1;
			assign sat_in  = sat_s1;
			assign rem_in  = rem_s1;
			assign quot_in = '0;
		end else begin : g_next
			assign d_in    = d_s2[s-1];
			assign prev_in = prev_s2[s-1];
			assign sat_in  = sat_s2[s-1];
			assign rem_in  = rem_s2[s-1];
			assign quot_in = quot_s2[s-1];
		end

		awsm_div_stage #(
			.WEIGHT_FRAC_BITS (F),
			.FIRST_BIT        (s * DIV_STEP)
		) u_div (
			.clk     (clk),
			.en      (en[s+1]),
			.divisor (cfg.max_distance),
			.rem_i   (rem_in),
			.quot_i  (quot_in),
			.rem_s2  (rem_s2[s]),
			.quot_s2 (quot_s2[s])
		);

		always_ff @(posedge clk) begin
			if (en[s+1]) begin
				d_s2[s]    <= d_in;
				prev_s2[s] <= prev_in;
				sat_s2[s]  <= sat_in;
			end
		end
	end

	// stage 3: alpha and (max - min) * alpha
	logic [F:0]              alpha_c;
	logic signed [WD-1:0]    wdiff_c;
	logic signed [PW-1:0]    prod_s3;
	logic signed [A-1:0]     d_s3;
	logic signed [A-1:0]     prev_s3;

	assign alpha_c = sat_s2[NDIV-1] ? W_ONE : {1'b0, quot_s2[NDIV-1]};
	assign wdiff_c = WD'(cfg.max_weight) - WD'(cfg.min_weight);

	always_ff @(posedge clk) begin
		if (en[S3]) begin
			prod_s3 <= PW'(wdiff_c) * signed'(PW'({1'b0, alpha_c}));
			d_s3    <= d_s2[NDIV-1];
			prev_s3 <= prev_s2[NDIV-1];
		end
	end

	// stage 4: interpolated weight (min weight if max_distance is zero), clamped to [0, 1]
	logic signed [PW-1:0] wmin_ext;
	logic signed [PW-1:0] wsel_c;
	logic [F:0]           w_c;
	logic [F:0]           w_s4;
	logic signed [A-1:0]  d_s4;
	logic signed [A-1:0]  prev_s4;

	assign wmin_ext = PW'(cfg.min_weight);

	always_comb begin
		if (cfg.max_distance == '0) wsel_c = wmin_ext;
		else                        wsel_c = wmin_ext + (prod_s3 >>> F);
		if (wsel_c < 0)            w_c = '0;
		else if (wsel_c > ONE_PW)  w_c = W_ONE;
		else                       w_c = wsel_c[F:0];
	end

	always_ff @(posedge clk) begin
		if (en[S4]) begin
			w_s4    <= w_c;
			d_s4    <= d_s3;
			prev_s4 <= prev_s3;
		end
	end

	// stage 5: difference times weight
	logic signed [DW-1:0] dw_s5;
	logic signed [A-1:0]  prev_s5;

	always_ff @(posedge clk) begin
		if (en[S5]) begin
			dw_s5   <= DW'(d_s4) * signed'(DW'({1'b0, w_s4}));
			prev_s5 <= prev_s4;
		end
	end

	// stage 6: floor shift and wrap around the turn
	logic signed [DW-1:0] step_c;
	logic signed [A-1:0]  smoothed_s6;

	assign step_c = dw_s5 >>> F;

	always_ff @(posedge clk) begin
		if (en[S6]) begin
			smoothed_s6 <= prev_s5 + step_c[A-1:0];
		end
	end

	assign smoothed = smoothed_s6;

	a_rem_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld[0] && !sat_s1 |-> rem_s1 < cfg.max_distance)
		else $error("stage 1 remainder not below max distance");

	a_rem_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld[NDIV] && !sat_s2[NDIV-1] |-> rem_s2[NDIV-1] < cfg.max_distance)
		else $error("divider remainder not below max distance");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld[S4] |-> w_s4 <= W_ONE)
		else $error("clamped weight above one");

endmodule
`default_nettype wire

// File: tb/angle_weighted_smoothing_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// angle_weighted_smoothing_tb
// Self-checking bench for the angle smoothing block. A queue-fed driver
// offers sample words, a predictor computes the smoothed angles of every
// accepted word, and a monitor compares each result word in order. The
// registers are rewritten over the APB port between phases, once the block
// has drained.
// ----------------------------------------------------------------------------
module angle_weighted_smoothing_tb;
	import awsm_pkg::*;

	localparam int     AB            = ANGLE_BITS_DEF;
	localparam int     FB            = WEIGHT_FRAC_BITS_DEF;
	localparam longint WEIGHT_ONE    = longint'(1) << FB;
	localparam int     LATENCY       = FB / DIV_STEP + 5;
	localparam int     SETTLE_CYCLES = LATENCY + 4;
	localparam int     CYCLE_LIMIT   = 1000000;
	localparam int     NUM_PHASES    = 8;
	localparam int     PHASE_WORDS   = 190;
	localparam int     STALL_AT      = 300;   // words sent before the long output stall
	localparam int     STALL_CYCLES  = 300;
	localparam int     MAX_REPORTS   = 10;
	// address slot past the register list; writes there must be dropped
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef logic signed [AB-1:0] angle_t;

	typedef struct packed {
		angle_t cur_yaw, cur_pitch, cur_roll;
		angle_t prev_yaw, prev_pitch, prev_roll;
	} angles_in_t;

	typedef struct packed {
		angle_t yaw, pitch, roll;
	} smoothed_t;

	// ------------------------------------------------------------------
	// Clock, reset, APB and channels
	// ------------------------------------------------------------------
	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	awsm_sample_if #(.ANGLE_BITS(AB)) sample_ch ();
	awsm_result_if #(.ANGLE_BITS(AB)) result_ch ();

	angle_weighted_smoothing #(
		.ANGLE_BITS       (AB),
		.WEIGHT_FRAC_BITS (FB)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------
	// shadow copy of the block's registers, kept in step with APB writes
	logic        [DIST_BITS-1:0] cfg_dist  = MAX_DIST_RST;
	logic signed [WREG_BITS-1:0] cfg_min_w = MIN_W_RST;
	logic signed [WREG_BITS-1:0] cfg_max_w = MAX_W_RST;

	angles_in_t pending_samples[$];    // words waiting to be offered
	smoothed_t  expected_smoothed[$];  // predictions, oldest first
	angles_in_t offered_word;          // word currently on the sample channel

	int unsigned src_gap_left    = 0;
	int unsigned snk_gap_left    = 0;
	int unsigned long_stall_left = 0;
	bit          long_stall_done = 1'b0;
	bit          src_idle_en     = 1'b1;
	bit          snk_idle_en     = 1'b1;
	int unsigned words_sent      = 0;
	int unsigned words_checked   = 0;
	int unsigned mismatch_count  = 0;
	int unsigned cycle_count     = 0;

	string field_name [3] = '{"smoothed_yaw", "smoothed_pitch", "smoothed_roll"};

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// One axis: wrapped shortest difference, alpha = |d| / max_distance
	// clamped to one, weight interpolated between min and max and clamped
	// to [0, 1], then previous + floor(d * weight), wrapped.
	function automatic angle_t smooth_angle(input angle_t cur, input angle_t prev);
		angle_t diff;
		longint d, mag, div_by, alpha, wmin, wmax, wt, step;
		diff   = cur - prev;            // natural wrap to a half-open half turn
		d      = diff;
		mag    = (d < 0) ? -d : d;      // half turn gives 2^(AB-1)
		div_by = cfg_dist;
		wmin   = cfg_min_w;
		wmax   = cfg_max_w;
		wt     = wmin;                  // zero max_distance: fixed min weight
		if (div_by != 0) begin
			alpha = (mag << FB) / div_by;
			if (alpha > WEIGHT_ONE)
				alpha = WEIGHT_ONE;
			wt = wmin + (((wmax - wmin) * alpha) >>> FB);
		end
		// only the final weight is clamped, not min/max themselves
		if (wt < 0)
			wt = 0;
		if (wt > WEIGHT_ONE)
			wt = WEIGHT_ONE;
		step = (d * wt) >>> FB;         // floor for negative products too
		return angle_t'(longint'(prev) + step);
	endfunction

	function automatic smoothed_t predict_smoothed(input angles_in_t w);
		smoothed_t r;
		r.yaw   = smooth_angle(w.cur_yaw,   w.prev_yaw);
		r.pitch = smooth_angle(w.cur_pitch, w.prev_pitch);
		r.roll  = smooth_angle(w.cur_roll,  w.prev_roll);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------
	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic angle_t extreme_angle();
		case ($urandom_range(5))
			0: return angle_t'(-32768);
			1: return angle_t'(-32767);
			2: return angle_t'(-1);
			3: return angle_t'(0);
			4: return angle_t'(1);
			default: return angle_t'(32767);
		endcase
	endfunction

	// Pairs are shaped so that the difference often falls near max_distance,
	// where alpha moves; the rest is uniform noise, near half turns and
	// extreme codes.
	function automatic void random_axis(input int span, output angle_t cur,
	                                    output angle_t prev);
		int unsigned kind;
		kind = $urandom_range(99);
		prev = angle_t'($urandom);
		if (kind < 35)
			cur = angle_t'($urandom);
		else if (kind < 80)
			cur = angle_t'(int'(prev) + int'($urandom_range(2 * span)) - span);
		else if (kind < 90)
			cur = angle_t'(int'(prev) + 32768 + int'($urandom_range(6)) - 3);
		else begin
			prev = extreme_angle();
			cur  = extreme_angle();
		end
	endfunction

	function automatic angles_in_t random_word();
		angles_in_t w;
		int span;
		if (cfg_dist == 0)
			span = 4096;
		else if (cfg_dist > 16384)
			span = 32768;
		else
			span = 2 * int'(cfg_dist);
		random_axis(span, w.cur_yaw,   w.prev_yaw);
		random_axis(span, w.cur_pitch, w.prev_pitch);
		random_axis(span, w.cur_roll,  w.prev_roll);
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus tasks
	// ------------------------------------------------------------------
	task automatic queue_word(input angle_t cy, input angle_t cp, input angle_t cr,
	                          input angle_t py, input angle_t pp, input angle_t pr);
		angles_in_t w;
		w = '{cy, cp, cr, py, pp, pr};
		pending_samples.push_back(w);
	endtask

	// APB write: setup cycle, access cycle, done at the edge with pready high.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MAX_DIST: cfg_dist  = value[DIST_BITS-1:0];
			REG_MIN_W:    cfg_min_w = value[WREG_BITS-1:0];
			REG_MAX_W:    cfg_max_w = value[WREG_BITS-1:0];
			default: ;    // unused slot, block ignores it
		endcase
	endtask

	// Block is idle once nothing is queued, offered or outstanding; checked
	// on the falling edge so the driver's updates of this cycle have landed.
	// Then let the pipeline settle before touching registers.
	task automatic wait_drained();
		while (pending_samples.size() != 0 || sample_ch.valid ||
		       expected_smoothed.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic log_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------
	// Sample driver: offers queued words, random gaps between words while src_idle_en is set.
	// A word accepted at this edge is predicted from what was on the bus.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			src_gap_left    <= 0;
		end else begin
			if (sample_ch.valid && sample_ch.ready) begin
				expected_smoothed.push_back(predict_smoothed(offered_word));
				words_sent <= words_sent + 1;
			end
			if (!sample_ch.valid || sample_ch.ready) begin
				if (src_gap_left != 0) begin
					sample_ch.valid <= 1'b0;
					src_gap_left    <= src_gap_left - 1;
				end else if (pending_samples.size() != 0) begin
					angles_in_t w;
					w = pending_samples.pop_front();
					offered_word             <= w;
					sample_ch.current_yaw    <= w.cur_yaw;
					sample_ch.current_pitch  <= w.cur_pitch;
					sample_ch.current_roll   <= w.cur_roll;
					sample_ch.previous_yaw   <= w.prev_yaw;
					sample_ch.previous_pitch <= w.prev_pitch;
					sample_ch.previous_roll  <= w.prev_roll;
					sample_ch.valid          <= 1'b1;
					src_gap_left             <= src_idle_en ? pick_gap() : 0;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Long output hold-off: once, partway through, ready stays low while
	// long_stall_left counts down and the driver keeps offering, so the pipe
	// fills and sample.ready has to drop.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			long_stall_left <= 0;
			long_stall_done <= 1'b0;
		end else if (long_stall_left != 0) begin
			long_stall_left <= long_stall_left - 1;
		end else if (!long_stall_done && words_sent >= STALL_AT) begin
			long_stall_left <= STALL_CYCLES;
			long_stall_done <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random ready gaps while snk_idle_en is set, in-order compare against predictions
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		smoothed_t want;
		angle_t    exp_f [3];
		angle_t    act_f [3];
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			snk_gap_left    <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				act_f = '{result_ch.smoothed_yaw, result_ch.smoothed_pitch,
				          result_ch.smoothed_roll};
				if (expected_smoothed.size() == 0) begin
					log_failure($sformatf("unexpected word yaw=%0d pitch=%0d roll=%0d",
					                      act_f[0], act_f[1], act_f[2]));
				end else begin
					want  = expected_smoothed.pop_front();
					exp_f = '{want.yaw, want.pitch, want.roll};
					for (int k = 0; k < 3; k++)
						if (act_f[k] !== exp_f[k])
							log_failure($sformatf("word %0d %s: expected %0d, got %0d",
							                      words_checked, field_name[k],
							                      exp_f[k], act_f[k]));
				end
				words_checked <= words_checked + 1;
			end
			if (long_stall_left != 0) begin
				result_ch.ready <= 1'b0;
			end else if (snk_gap_left != 0) begin
				result_ch.ready <= 1'b0;
				snk_gap_left    <= snk_gap_left - 1;
			end else begin
				result_ch.ready <= 1'b1;
				snk_gap_left    <= snk_idle_en ? pick_gap() : 0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence: reset, directed words under reset values, then phases of
	// register settings (extremes first, then random) with random words.
	// ------------------------------------------------------------------
	initial begin
		int unsigned ph_dist;
		int          ph_min;
		int          ph_max;

		sample_ch.valid          = 1'b0;
		sample_ch.current_yaw    = '0;
		sample_ch.current_pitch  = '0;
		sample_ch.current_roll   = '0;
		sample_ch.previous_yaw   = '0;
		sample_ch.previous_pitch = '0;
		sample_ch.previous_roll  = '0;
		result_ch.ready          = 1'b0;
		offered_word             = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words, reset values: zero max_distance, fixed weight 0.5
		queue_word(0, 0, 0, 0, 0, 0);
		queue_word(-32768, -32768, -32768, -32768, -32768, -32768);
		queue_word(32767, 32767, 32767, 32767, 32767, 32767);
		// across the wrap point, both directions
		queue_word(32767, -32768, 1, -32768, 32767, 0);
		// difference of exactly a half turn on every axis
		queue_word(-32768, 0, 16384, 0, -32768, -16384);
		queue_word(-1, 1, -32767, 0, 0, 1);
		queue_word(21845, -21846, 21845, -21846, 21845, -21846);
		queue_word(-21846, 21845, -21846, 21845, -21846, 21845);
		queue_word(100, -100, 32000, 0, 0, -32000);
		queue_word(12345, -23456, 30000, -12345, 23456, -30000);
		queue_word(3, -3, 7, 0, 0, 0);
		queue_word(-32767, 32766, -2, 32767, -32768, 2);
		wait_drained();

		for (int ph = 1; ph <= NUM_PHASES; ph++) begin
			case (ph)
				1: begin ph_dist = 0;     ph_min = 65536;   ph_max = 0;       end
				2: begin ph_dist = 32768; ph_min = 0;       ph_max = 65536;   end
				3: begin ph_dist = 1;     ph_min = -131072; ph_max = 131072;  end
				4: begin ph_dist = 65535; ph_min = 131072;  ph_max = -131072; end
				5: begin ph_dist = 0;     ph_min = -131072; ph_max = 131072;  end
				default: begin
					ph_dist = ($urandom_range(3) == 0) ? $urandom_range(32768)
					                                   : $urandom_range(2048, 1);
					ph_min  = int'($urandom_range(65536));
					ph_max  = ($urandom_range(2) == 0)
					          ? int'($urandom_range(262144)) - 131072
					          : int'($urandom_range(65536));
				end
			endcase
			write_reg(REG_MAX_DIST, ph_dist);
			write_reg(REG_MIN_W, ph_min);
			write_reg(REG_MAX_W, ph_max);
			// stray write past the register list must change nothing
			if (ph == 3)
				write_reg(REG_UNUSED, 32'hFFFF_FFFF);

			// vary which side idles; some phases run one side flat out
			src_idle_en <= (ph % 3 != 1);
			snk_idle_en <= (ph % 3 != 2);
			repeat (PHASE_WORDS) pending_samples.push_back(random_word());
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
rtl/awsm_pkg.sv
rtl/awsm_sample_if.sv
rtl/awsm_result_if.sv
rtl/awsm_cfg.sv
rtl/awsm_div_stage.sv
rtl/awsm_axis.sv
rtl/angle_weighted_smoothing.sv
tb/angle_weighted_smoothing_tb.sv
